@@ hdl/xgmii_rx_frame_decoder_top_defines.svh @@
// assertion macros for the xgmii receive frame decoder
// included by xgmii_rx_frame_decoder_top.sv, no other dependencies
`ifndef XGMII_RX_FRAME_DECODER_TOP_DEFINES_SVH
`define XGMII_RX_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define XRFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xrfd check failed");

// next-cycle implication, checked out of reset
`define XRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xrfd check failed");

`endif

@@ hdl/xrfd_pkg.sv @@
// shared types and constants for the xgmii receive frame decoder
// no dependencies
package xrfd_pkg;

    localparam int DATA_W    = 64;
    localparam int CTRL_W    = 8;
    localparam int BCNT_W    = 4;
    localparam int MAX_LANES = 8;
    localparam int MAX_SEGS  = MAX_LANES / 2 + 1;
    localparam int SEG_W     = $clog2(MAX_SEGS);
    localparam int POS_W     = $clog2(MAX_LANES);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_START = 8'hfb;
    localparam logic [7:0] CH_TERM  = 8'hfd;
    localparam logic [7:0] CH_IDLE  = 8'h07;

    typedef struct packed {
        logic [DATA_W-1:0] lane_data;
        logic [CTRL_W-1:0] lane_ctrl;
    } t_xgmii_word;

    typedef struct packed {
        logic [DATA_W-1:0] packed_bytes;
        logic [BCNT_W-1:0] byte_count;
        logic              starts_packet;
        logic              ends_packet;
        logic              dup_start;
        logic              stray_end;
        logic              last;
    } t_rx_result;

    // one classified word: lane routing plus per-segment summary
    typedef struct packed {
        logic [DATA_W-1:0]                lane_data;
        logic [MAX_LANES-1:0]             keep;
        logic [MAX_LANES-1:0][SEG_W-1:0]  seg;
        logic [MAX_LANES-1:0][POS_W-1:0]  pos;
        logic [MAX_SEGS-1:0][BCNT_W-1:0]  seg_cnt;
        logic [MAX_SEGS-1:0]              opened;
        logic [SEG_W-1:0]                 n_term;
        logic                             dup;
        logic                             stray;
    } t_word_rec;

    typedef struct packed {
        logic      wr;
        t_word_rec rec;
    } t_q_write;

    typedef struct packed {
        logic      valid;
        t_word_rec rec;
    } t_q_head;

endpackage

@@ hdl/xgmii_rx_frame_decoder_top.sv @@
// channel   direction  handshake       payload
// word in   input      push / full     i_in  (xrfd_pkg::t_xgmii_word)
// result    output     empty / pop     o_out (xrfd_pkg::t_rx_result)
//
// one word is taken per cycle while the queue is not full; it gives n_term + 1
// results (one to five), and the back end registers one result per cycle while its
// single result register is free or being popped. the first result is registered
// after the word is written into the two-entry queue. synchronous active-low reset
// clears the in-packet flag, queue pointers and result valid. full rises only when
// both queue entries hold words; a stalled result register holds its value.
// top level of the xgmii receive frame decoder, depends on xrfd_pkg,
// xrfd_front, xrfd_queue, xrfd_back and xgmii_rx_frame_decoder_top_defines.svh
`include "xgmii_rx_frame_decoder_top_defines.svh"

module xgmii_rx_frame_decoder_top #(
    parameter int LANES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  xrfd_pkg::t_xgmii_word i_in,
    output logic                  empty,
    input  logic                  pop,
    output xrfd_pkg::t_rx_result  o_out
);
    import xrfd_pkg::*;

    t_q_write q_wr;
    t_q_head  q_head;
    logic     q_pop;

    xrfd_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_in    (i_in),
        .i_full  (full),
        .o_wr    (q_wr)
    );

    xrfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_head  (q_head)
    );

    xrfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_q_pop (q_pop),
        .o_empty (empty),
        .i_pop   (pop),
        .o_out   (o_out)
    );

    `XRFD_ASSERT_NOW(a_mid_result_is_segment, i_clk, i_rst_n, !empty && !o_out.last, o_out.ends_packet && !o_out.dup_start && !o_out.stray_end)
    `XRFD_ASSERT_NOW(a_last_not_segment, i_clk, i_rst_n, !empty && o_out.last, !o_out.ends_packet)
    `XRFD_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, !empty, o_out.byte_count <= LANES)
    `XRFD_ASSERT_NEXT(a_no_result_from_nothing, i_clk, i_rst_n, empty && !q_head.valid, empty)

endmodule

@@ hdl/xrfd_front.sv @@
// front end: accepts xgmii words, scans lanes and tracks the in-packet flag
// depends on xrfd_pkg
module xrfd_front #(
    parameter int LANES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xrfd_pkg::t_xgmii_word i_in,
    input  logic                 i_full,
    output xrfd_pkg::t_q_write   o_wr
);
    import xrfd_pkg::*;

    logic              r_in_packet;
    logic              n_in_packet;
    logic              accept;
    t_word_rec         rec;
    logic              ip;
    logic [SEG_W-1:0]  seg;
    logic [BCNT_W-1:0] cnt;
    logic [7:0]        lane_byte;

    assign accept = i_push && !i_full;

    always_comb begin
        rec       = '0;
        ip        = r_in_packet;
        seg       = '0;
        cnt       = '0;
        lane_byte = '0;
        for (int l = 0; l < MAX_LANES; l++) begin
            if (l < LANES) begin
                lane_byte = i_in.lane_data[8*l +: 8];
                if (!i_in.lane_ctrl[l]) begin
                    if (ip) begin
                        rec.keep[l] = 1'b1;
                        rec.seg[l]  = seg;
                        rec.pos[l]  = cnt[POS_W-1:0];
                        cnt         = cnt + 1'b1;
                    end
                end else begin
                    case (lane_byte)
                        CH_START: begin
                            if (ip) begin
                                rec.dup = 1'b1;
                            end else begin
                                ip               = 1'b1;
                                rec.opened[seg]  = 1'b1;
                                cnt              = '0;
                            end
                        end
                        CH_TERM: begin
                            if (!ip) begin
                                rec.stray = 1'b1;
                            end else begin
                                rec.seg_cnt[seg] = cnt;
                                seg              = seg + 1'b1;
                                ip               = 1'b0;
                                cnt              = '0;
                            end
                        end
                        CH_IDLE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        rec.seg_cnt[seg] = cnt;
        rec.n_term       = seg;
        rec.lane_data    = i_in.lane_data;
        n_in_packet      = accept ? ip : r_in_packet;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
        end else begin
            r_in_packet <= n_in_packet;
        end
    end

    assign o_wr.wr  = accept;
    assign o_wr.rec = rec;

endmodule

@@ hdl/xrfd_queue.sv @@
// short queue of classified words between front and back end
// depends on xrfd_pkg
module xrfd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xrfd_pkg::t_q_write i_wr,
    input  logic               i_pop,
    output logic               o_full,
    output xrfd_pkg::t_q_head  o_head
);
    import xrfd_pkg::*;

    t_word_rec          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.rec   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_mem[r_wr_ptr] <= i_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr.wr, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/xrfd_back.sv @@
// back end: walks the segments of the head word and registers one result per cycle
// while its result register is free or being popped; depends on xrfd_pkg
module xrfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xrfd_pkg::t_q_head    i_head,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output xrfd_pkg::t_rx_result o_out
);
    import xrfd_pkg::*;

    logic [SEG_W-1:0] r_k;
    logic             r_out_valid;
    t_rx_result       r_out;
    t_rx_result       res;
    logic             is_last;
    logic             load;

    always_comb begin
        res     = '0;
        is_last = (r_k == i_head.rec.n_term);
        for (int p = 0; p < MAX_LANES; p++) begin
            for (int l = 0; l < MAX_LANES; l++) begin
                if (i_head.rec.keep[l] && i_head.rec.seg[l] == r_k
                        && i_head.rec.pos[l] == p[POS_W-1:0]) begin
                    res.packed_bytes[8*p +: 8] = i_head.rec.lane_data[8*l +: 8];
                end
            end
        end
        res.byte_count    = i_head.rec.seg_cnt[r_k];
        res.starts_packet = i_head.rec.opened[r_k];
        res.ends_packet   = !is_last;
        res.dup_start     = is_last && i_head.rec.dup;
        res.stray_end     = is_last && i_head.rec.stray;
        res.last          = is_last;
    end

    assign load    = i_head.valid && (!r_out_valid || i_pop);
    assign o_q_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_k         <= is_last ? '0 : r_k + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

@@ tb/xgmii_rx_frame_decoder_top_tb.sv @@
// self-checking testbench for the xgmii receive frame decoder: directed words, random frames
// and a back-pressure run, each result checked against an in-bench decoder
// depends on xrfd_pkg and xgmii_rx_frame_decoder_top
module xgmii_rx_frame_decoder_top_tb;
    import xrfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       ctrl;
        logic [7:0] code;
    } t_lane_char;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    t_xgmii_word i_in    = '0;
    logic        full;
    logic        empty;
    t_rx_result  o_out;

    t_rx_result  pending_results[$];
    t_lane_char  lane_stream[$];
    logic        pkt_open     = 1'b0;
    int          err_cnt      = 0;
    int          cycle_cnt    = 0;
    int          burst_left   = 0;
    logic        rx_hold_req  = 1'b0;
    int          rx_hold_left = 0;
    int          rx_mode      = 0;
    int          rx_cycle     = 0;

    xgmii_rx_frame_decoder_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_in   (i_in),
        .empty  (empty),
        .pop    (pop),
        .o_out  (o_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("xgmii_rx_frame_decoder_top_tb: done, errors");
            $finish;
        end
    end

    // lane scan of one word, results appended to the expected store
    function automatic void decode_word(input t_xgmii_word w);
        logic [63:0] acc;
        int          cnt;
        int          n;
        int          lane;
        logic        opened;
        logic        dup;
        logic        stray;
        logic [7:0]  b;
        t_rx_result  r;
        acc    = '0;
        cnt    = 0;
        n      = 0;
        opened = 1'b0;
        dup    = 1'b0;
        stray  = 1'b0;
        for (lane = 0; lane < MAX_LANES; lane++) begin
            b = w.lane_data[8*lane +: 8];
            if (!w.lane_ctrl[lane]) begin
                if (pkt_open && cnt < 8) begin
                    acc[8*cnt +: 8] = b;
                    cnt++;
                end
            end else if (b == CH_START) begin
                if (pkt_open) begin
                    dup = 1'b1;
                end else begin
                    pkt_open = 1'b1;
                    opened   = 1'b1;
                    acc      = '0;
                    cnt      = 0;
                end
            end else if (b == CH_TERM) begin
                if (!pkt_open) begin
                    stray = 1'b1;
                end else begin
                    if (n < 4) begin
                        r = '{packed_bytes: acc, byte_count: 4'(cnt), starts_packet: opened,
                              ends_packet: 1'b1, dup_start: 1'b0, stray_end: 1'b0,
                              last: 1'b0};
                        pending_results.push_back(r);
                    end
                    n++;
                    pkt_open = 1'b0;
                    acc      = '0;
                    cnt      = 0;
                    opened   = 1'b0;
                end
            end
        end
        r = '{packed_bytes: acc, byte_count: 4'(cnt), starts_packet: opened,
              ends_packet: 1'b0, dup_start: dup, stray_end: stray, last: 1'b1};
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_cnt++;
        if (err_cnt <= 50)
            $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    task automatic check_result(input t_rx_result got);
        t_rx_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", got.packed_bytes, '0);
        end else begin
            want = pending_results.pop_front();
            if (got.packed_bytes !== want.packed_bytes)
                report_mismatch("packed_bytes", got.packed_bytes, want.packed_bytes);
            if (got.byte_count !== want.byte_count)
                report_mismatch("byte_count", 64'(got.byte_count), 64'(want.byte_count));
            if (got.starts_packet !== want.starts_packet)
                report_mismatch("starts_packet", 64'(got.starts_packet),
                                64'(want.starts_packet));
            if (got.ends_packet !== want.ends_packet)
                report_mismatch("ends_packet", 64'(got.ends_packet), 64'(want.ends_packet));
            if (got.dup_start !== want.dup_start)
                report_mismatch("dup_start", 64'(got.dup_start), 64'(want.dup_start));
            if (got.stray_end !== want.stray_end)
                report_mismatch("stray_end", 64'(got.stray_end), 64'(want.stray_end));
            if (got.last !== want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    // result side: check each transfer, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_result(o_out);
        rx_cycle++;
        if (rx_cycle % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_hold_req) begin
            rx_hold_left = 300;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    pop <= 1'b1;
                end
                1: begin
                    pop <= ($urandom_range(0, 1) == 0);
                end
                2: begin
                    pop <= (rx_cycle % 4 == 0);
                end
                default: begin
                    pop <= ($urandom_range(0, 99) < 85);
                end
            endcase
        end
    end

    task automatic send_word(input logic [63:0] data, input logic [7:0] ctrl);
        t_xgmii_word w;
        w.lane_data = data;
        w.lane_ctrl = ctrl;
        i_in <= w;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_word(w);
    endtask

    task automatic send_paced(input logic [63:0] data, input logic [7:0] ctrl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_word(data, ctrl);
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_char(input logic ctrl, input logic [7:0] code);
        t_lane_char c;
        c.ctrl = ctrl;
        c.code = code;
        lane_stream.push_back(c);
    endfunction

    // one frame with idles ahead of it, sometimes malformed
    function automatic void add_frame();
        int kind;
        int len;
        int k;
        kind = $urandom_range(0, 19);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 20);
        repeat ($urandom_range(0, 6)) add_char(1'b1, CH_IDLE);
        if (kind != 17)
            add_char(1'b1, CH_START);
        for (k = 0; k < len; k++) begin
            add_char(1'b0, 8'($urandom_range(0, 255)));
            if (kind == 18 && k == len / 2)
                add_char(1'b1, CH_START);
            if (kind == 19 && k == len / 2)
                add_char(1'b1, 8'($urandom_range(0, 255)));
        end
        if (kind != 16)
            add_char(1'b1, CH_TERM);
    endfunction

    task automatic send_from_stream(input logic paced);
        logic [63:0] data;
        logic [7:0]  ctrl;
        int          lane;
        t_lane_char  c;
        while (lane_stream.size() < MAX_LANES) add_frame();
        for (lane = 0; lane < MAX_LANES; lane++) begin
            c = lane_stream.pop_front();
            data[8*lane +: 8] = c.code;
            ctrl[lane]        = c.ctrl;
        end
        if (paced)
            send_paced(data, ctrl);
        else
            send_word(data, ctrl);
    endtask

    task automatic send_noise();
        logic [63:0] data;
        int          lane;
        int          pick;
        for (lane = 0; lane < MAX_LANES; lane++) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       data[8*lane +: 8] = CH_START;
                1:       data[8*lane +: 8] = CH_TERM;
                2:       data[8*lane +: 8] = CH_IDLE;
                default: data[8*lane +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        send_paced(data, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        // idle word, data outside a packet, stray terminate
        send_paced({8{CH_IDLE}}, 8'hff);
        send_paced(64'hffff_ffff_ffff_ffff, 8'h00);
        send_paced({{7{CH_IDLE}}, CH_TERM}, 8'hff);
        // start in lane 0, then full data words
        send_paced({56'hffee_ddcc_bbaa_99, CH_START}, 8'h01);
        send_paced(64'hffff_ffff_ffff_ffff, 8'h00);
        send_paced(64'h0, 8'h00);
        // duplicate start in lane 3
        send_paced({32'h1122_3344, CH_START, 24'haabb_cc}, 8'h08);
        // terminate in lane 7 after seven bytes
        send_paced({CH_TERM, 56'h0102_0304_0506_07}, 8'h80);
        // start in lane 4, then terminate in lane 0 with nothing pending
        send_paced({24'h5566_77, CH_START, {4{CH_IDLE}}}, 8'h1f);
        send_paced({{7{CH_IDLE}}, CH_TERM}, 8'hff);
        // four segments in one word
        send_paced({{7{CH_IDLE}}, CH_START}, 8'hff);
        send_paced({CH_START, CH_TERM, CH_START, CH_TERM,
                    CH_START, CH_TERM, CH_START, CH_TERM}, 8'hff);
        // duplicate start, stray terminate and an unknown code in one word
        send_paced({CH_START, CH_IDLE, 8'h5a, 8'hfe, CH_TERM, CH_TERM, 8'ha5, CH_START},
                   8'hdd);
        // control values carried as data
        send_paced({{4{CH_START}}, {4{CH_TERM}}}, 8'h00);
        send_paced(64'hffff_ffff_ffff_ffff, 8'hff);
        send_paced({{7{CH_IDLE}}, CH_TERM}, 8'hff);
        send_paced(64'h0, 8'hff);
        wait_all_results();
    endtask

    task automatic test_random_frames(input int n_words);
        int k;
        for (k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_from_stream(1'b1);
            if (k == n_words / 2)
                wait_all_results();
        end
        wait_all_results();
    endtask

    task automatic test_full_queue(input int n_words);
        rx_hold_req = 1'b1;
        repeat (n_words) send_from_stream(1'b0);
        wait_all_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(125);
        test_full_queue(40);
        test_random_frames(20);
        repeat (16) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("xgmii_rx_frame_decoder_top_tb: done, clean");
        end else begin
            $display("xgmii_rx_frame_decoder_top_tb: done, errors");
        end
        $finish;
    end
endmodule
